>>> design/tksu_pkg.sv
// Shared types and status codes of the top-k score table update unit.
package tksu_pkg;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] score;
    logic [23:0] payload;
  } entry_t;

  typedef enum logic [1:0] {
    ST_BELOW      = 2'd0,
    ST_RANKED     = 2'd1,
    ST_APPENDED   = 2'd2,
    ST_NOT_PLACED = 2'd3
  } status_t;

endpackage

>>> design/tksu_mem.sv
// Entry memory of the score table: one write port and one registered read port.
module tksu_mem #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic             clk,
  input  logic [IW-1:0]    rd_addr,
  output tksu_pkg::entry_t rd_data,
  input  logic             wr_en,
  input  logic [IW-1:0]    wr_addr,
  input  tksu_pkg::entry_t wr_data
);
  import tksu_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/top_k_score_table_update_unit.sv
// Top level of the top-k score table update unit: sequencer, compare unit and table.
//
//   channel  ports                                    handshake
//   in       in_player_id, in_score, in_job_code,     start high while busy low
//            in_sex_code, in_level_byte
//   out      out_status, out_position, out_old_removed, out_valid for one cycle
//            out_entry_count, out_threshold
//
// A beat below the threshold keeps busy low and gives its result in the next cycle.
// Any other beat raises busy and runs the states SCAN, PLAN, SHIFT, DRAIN and PUT in
// that order; SHIFT and DRAIN are skipped when nothing moves, SCAN when the table is
// empty, and a beat that is not placed ends in PLAN. The result shows in the cycle in
// which busy falls. The single read port of the table is read once per cycle by the
// scan and the move loops, so the busy time grows with the entry count and the moves.
// Reset empties the table and clears the threshold.
// The receiver cannot stall; each result is shown once, and busy is low when it shows.
module top_k_score_table_update_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_player_id,
  input  logic [31:0] in_score,
  input  logic [7:0]  in_job_code,
  input  logic [7:0]  in_sex_code,
  input  logic [7:0]  in_level_byte,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_position,
  output logic        out_old_removed,
  output logic [8:0]  out_entry_count,
  output logic [31:0] out_threshold
);
  import tksu_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_I = IW'(TABLE_DEPTH - 1);
  localparam logic [CW:0] DEPTH_X = (CW+1)'(TABLE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_PLAN  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_DRAIN = 6'b010000,
    S_PUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] thr_r, thr_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [31:0] id_r, id_nxt, sc_r, sc_nxt;
  logic [23:0] pl_r, pl_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic chk_v_r, chk_v_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic found_m_r, found_m_nxt, found_k_r, found_k_nxt;
  logic [IW-1:0] m_r, m_nxt, k_r, k_nxt;
  logic [31:0] tail_sc_r, tail_sc_nxt;
  logic [IW-1:0] ins_r, ins_nxt, src_r, src_nxt;
  logic up_r, up_nxt;
  logic [CW-1:0] cnt_new_r, cnt_new_nxt;
  logic [31:0] thr_new_r, thr_new_nxt;
  status_t st_r, st_nxt;
  logic wv_r, wv_nxt;
  logic [IW-1:0] wdst_r, wdst_nxt;

  status_t o_st_r, o_st_nxt;
  logic [7:0] o_pos_r, o_pos_nxt;
  logic o_rem_r, o_rem_nxt;
  logic [8:0] o_cnt_r, o_cnt_nxt;
  logic [31:0] o_thr_r, o_thr_nxt;

  logic [IW-1:0] rd_addr;
  entry_t rd_data;
  logic wr_en;
  logic [IW-1:0] wr_addr;
  entry_t wr_data;

  logic is_match, first_m, beat;
  logic [CW:0] chk_ext;
  logic [CW-1:0] n_rem;
  logic [IW-1:0] plan_ins, m_eff;
  logic plan_ranked, plan_placed, plan_up, plan_zero;

  tksu_mem #(.DEPTH(TABLE_DEPTH), .IW(IW)) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign is_match = (rd_data.id == id_r);
  assign first_m  = is_match && !found_m_r;
  assign beat     = (sc_r > rd_data.score) && !first_m;
  assign chk_ext  = (CW+1)'(chk_idx_r) + (CW+1)'(2);

  assign n_rem       = cnt_r - CW'(found_m_r);
  assign plan_ranked = found_k_r;
  assign plan_placed = found_k_r || (n_rem < DEPTH_C);
  assign plan_ins    = found_k_r ? ((found_m_r && (m_r < k_r)) ? (k_r - IW'(1)) : k_r)
                                 : n_rem[IW-1:0];
  assign m_eff       = found_m_r ? m_r
                                 : ((cnt_r == DEPTH_C) ? LAST_I : cnt_r[IW-1:0]);
  assign plan_up     = !found_m_r || (plan_ins <= m_r);
  assign plan_zero   = plan_up ? (m_eff == plan_ins) : (m_r == plan_ins);

  assign rd_addr = (state_r == S_SCAN) ? iss_r[IW-1:0] : src_r;
  assign wr_en   = wv_r || (state_r == S_PUT);
  assign wr_addr = (state_r == S_PUT) ? ins_r : wdst_r;
  assign wr_data = (state_r == S_PUT) ? entry_t'{id: id_r, score: sc_r, payload: pl_r}
                                      : rd_data;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    thr_nxt       = thr_r;
    out_valid_nxt = 1'b0;
    id_nxt        = id_r;
    sc_nxt        = sc_r;
    pl_nxt        = pl_r;
    iss_nxt       = iss_r;
    chk_v_nxt     = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    found_m_nxt   = found_m_r;
    found_k_nxt   = found_k_r;
    m_nxt         = m_r;
    k_nxt         = k_r;
    tail_sc_nxt   = tail_sc_r;
    ins_nxt       = ins_r;
    src_nxt       = src_r;
    up_nxt        = up_r;
    cnt_new_nxt   = cnt_new_r;
    thr_new_nxt   = thr_new_r;
    st_nxt        = st_r;
    wv_nxt        = 1'b0;
    wdst_nxt      = wdst_r;
    o_st_nxt      = o_st_r;
    o_pos_nxt     = o_pos_r;
    o_rem_nxt     = o_rem_r;
    o_cnt_nxt     = o_cnt_r;
    o_thr_nxt     = o_thr_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_score < thr_r) begin
            out_valid_nxt = 1'b1;
            o_st_nxt      = ST_BELOW;
            o_pos_nxt     = 8'd0;
            o_rem_nxt     = 1'b0;
            o_cnt_nxt     = 9'(cnt_r);
            o_thr_nxt     = thr_r;
          end else begin
            id_nxt      = in_player_id;
            sc_nxt      = in_score;
            pl_nxt      = {in_level_byte, in_sex_code, in_job_code};
            iss_nxt     = '0;
            found_m_nxt = 1'b0;
            found_k_nxt = 1'b0;
            state_nxt   = (cnt_r == '0) ? S_PLAN : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (iss_r != cnt_r) begin
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = iss_r[IW-1:0];
          iss_nxt     = iss_r + CW'(1);
        end
        if (chk_v_r) begin
          if (first_m) begin
            found_m_nxt = 1'b1;
            m_nxt       = chk_idx_r;
          end
          if (beat && !found_k_r) begin
            found_k_nxt = 1'b1;
            k_nxt       = chk_idx_r;
          end
          if (chk_ext == DEPTH_X) begin
            tail_sc_nxt = rd_data.score;
          end
          if (iss_r == cnt_r) begin
            state_nxt = S_PLAN;
          end
        end
      end
      S_PLAN: begin
        ins_nxt     = plan_ins;
        up_nxt      = plan_up;
        src_nxt     = plan_up ? (m_eff - IW'(1)) : (m_r + IW'(1));
        cnt_new_nxt = (n_rem == DEPTH_C) ? DEPTH_C : (n_rem + CW'(1));
        st_nxt      = plan_ranked ? ST_RANKED : ST_APPENDED;
        thr_new_nxt = thr_r;
        if (plan_ranked && !found_m_r && (cnt_r == DEPTH_C)) begin
          thr_new_nxt = (plan_ins == LAST_I) ? sc_r : tail_sc_r;
        end
        if (!plan_placed) begin
          out_valid_nxt = 1'b1;
          o_st_nxt      = ST_NOT_PLACED;
          o_pos_nxt     = 8'd0;
          o_rem_nxt     = found_m_r;
          o_cnt_nxt     = 9'(n_rem);
          o_thr_nxt     = thr_r;
          cnt_nxt       = n_rem;
          state_nxt     = S_IDLE;
        end else if (plan_zero) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        wv_nxt   = 1'b1;
        wdst_nxt = up_r ? (src_r + IW'(1)) : (src_r - IW'(1));
        if (src_r == ins_r) begin
          state_nxt = S_DRAIN;
        end else begin
          src_nxt = up_r ? (src_r - IW'(1)) : (src_r + IW'(1));
        end
      end
      S_DRAIN: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        cnt_nxt       = cnt_new_r;
        thr_nxt       = thr_new_r;
        out_valid_nxt = 1'b1;
        o_st_nxt      = st_r;
        o_pos_nxt     = 8'(ins_r);
        o_rem_nxt     = found_m_r;
        o_cnt_nxt     = 9'(cnt_new_r);
        o_thr_nxt     = thr_new_r;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
      wv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
      chk_v_r     <= chk_v_nxt;
      wv_r        <= wv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    sc_r      <= sc_nxt;
    pl_r      <= pl_nxt;
    iss_r     <= iss_nxt;
    chk_idx_r <= chk_idx_nxt;
    found_m_r <= found_m_nxt;
    found_k_r <= found_k_nxt;
    m_r       <= m_nxt;
    k_r       <= k_nxt;
    tail_sc_r <= tail_sc_nxt;
    ins_r     <= ins_nxt;
    src_r     <= src_nxt;
    up_r      <= up_nxt;
    cnt_new_r <= cnt_new_nxt;
    thr_new_r <= thr_new_nxt;
    st_r      <= st_nxt;
    wdst_r    <= wdst_nxt;
    o_st_r    <= o_st_nxt;
    o_pos_r   <= o_pos_nxt;
    o_rem_r   <= o_rem_nxt;
    o_cnt_r   <= o_cnt_nxt;
    o_thr_r   <= o_thr_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = o_st_r;
  assign out_position    = o_pos_r;
  assign out_old_removed = o_rem_r;
  assign out_entry_count = o_cnt_r;
  assign out_threshold   = o_thr_r;

endmodule
